### rtl/core/relay_mode_controller_defines.svh
// ----------------------------------------------------------------------------
// Relay mode controller assertion macros
// Shared property forms for the relay mode controller checker.
// ----------------------------------------------------------------------------
`ifndef RELAY_MODE_CONTROLLER_DEFINES_SVH
`define RELAY_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication that also holds across reset.
`define RMC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/rmc_pkg.sv
// ----------------------------------------------------------------------------
// Relay mode controller package
// Types, register indexes and constants shared by the relay controller files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmc_pkg;

  localparam int unsigned CfgDataWidth = 24;
  localparam int unsigned CfgIndexWidth = 3;

  localparam logic [10:0] MINUTES_PER_DAY = 11'd1440;
  localparam logic [31:0] MS_PER_MINUTE = 32'd60000;

  typedef logic signed [23:0] reading_t;
  typedef logic [15:0] ms_delta_t;
  typedef logic [10:0] minute_t;
  typedef logic [15:0] minutes_len_t;
  typedef logic [31:0] ms_count_t;
  typedef logic [CfgDataWidth-1:0] cfg_data_t;

  typedef enum logic [1:0] {
    MODE_FORCED,
    MODE_HYSTERESIS,
    MODE_CYCLIC,
    MODE_SCHEDULED
  } mode_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_RELAY_MODE,
    CFG_MANUAL_TARGET,
    CFG_ON_THRESHOLD,
    CFG_OFF_THRESHOLD,
    CFG_CYCLIC_ON,
    CFG_CYCLIC_OFF,
    CFG_WINDOW_START,
    CFG_WINDOW_LENGTH
  } cfg_index_t;

  // Register reset values.
  localparam reading_t ON_THRESHOLD_RESET = 24'sd100000;
  localparam reading_t OFF_THRESHOLD_RESET = 24'sd80000;
  localparam ms_count_t CYCLIC_ON_MS_RESET = 32'd1800000;
  localparam ms_count_t CYCLIC_OFF_MS_RESET = 32'd600000;
  localparam minute_t WINDOW_START_RESET = 11'd1320;
  localparam minutes_len_t WINDOW_LENGTH_RESET = 16'd30;

  // Fold a minute value into one day; inputs never exceed two days.
  function automatic minute_t wrap_day(input minute_t m);
    wrap_day = (m >= MINUTES_PER_DAY) ? m - MINUTES_PER_DAY : m;
  endfunction

endpackage

### rtl/core/relay_mode_controller.sv
// ----------------------------------------------------------------------------
// Relay mode controller
// Drives one relay from evaluation ticks in manual, auto, cyclic or
// scheduled mode. Input channel: one tick per transaction (elapsed_ms,
// sensor reading and valid, minute of day and valid). Output channel: one
// transaction per tick with relay_on, state_changed and report_event.
// Configuration: cfg_write with cfg_index and cfg_data, taken at the edge.
// Timing: the accepting edge captures the tick in an input register, the
// next evaluates it into the result register and raises out_valid.
// Throughput is one tick per clock while the receiver does not stall; the
// relay, phase and timer state feed straight back into the evaluation
// logic, so ticks follow back to back.
// A stalled receiver holds the result register; the input register then
// keeps one more tick, and in_ready drops only when both are full.
// Reset empties both stages, clears relay and phase state and loads the
// register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module relay_mode_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rmc_pkg::ms_delta_t                   elapsed_ms,
  input  rmc_pkg::reading_t                    sensor_value,
  input  logic                                 sensor_valid,
  input  rmc_pkg::minute_t                     minute_of_day,
  input  logic                                 clock_valid,
  // Output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 relay_on,
  output logic                                 state_changed,
  output logic                                 report_event,
  // Configuration port
  input  logic                                 cfg_write,
  input  logic [rmc_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  rmc_pkg::cfg_data_t                   cfg_data
);

  import rmc_pkg::*;

  // Configuration registers. Cyclic lengths are kept in milliseconds, the
  // product being taken once when the register is written.
  mode_t        relay_mode;
  logic         manual_target;
  reading_t     on_threshold;
  reading_t     off_threshold;
  ms_count_t    cyclic_on_ms;
  ms_count_t    cyclic_off_ms;
  minute_t      window_start;
  minutes_len_t window_length;

  // Controller state
  logic         relay_state;
  logic         phase_is_on;
  ms_count_t    phase_elapsed;

  // Input register
  logic         tick_valid;
  ms_delta_t    tick_elapsed;
  reading_t     tick_value;
  logic         tick_sensor_ok;
  minute_t      tick_minute;
  logic         tick_clock_ok;

  // Evaluation results
  logic         relay_state_next;
  logic         phase_is_on_next;
  ms_count_t    phase_elapsed_next;
  logic         event_next;
  logic         changed_next;

  logic [32:0]  elapsed_sum;
  ms_count_t    elapsed_sat;
  ms_count_t    phase_len;
  minute_t      now_minute;
  logic [11:0]  window_diff;
  minute_t      window_offset;

  logic         out_free;
  logic         tick_move;
  logic         in_take;

  // Result register moves when empty or taken; the input register drains
  // into it in the same cycle.
  assign out_free  = !out_valid || out_ready;
  assign tick_move = tick_valid && out_free;
  assign in_ready  = !tick_valid || out_free;
  assign in_take   = in_valid && in_ready;

  // Capture the tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_ready) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tick_elapsed   <= elapsed_ms;
      tick_value     <= sensor_value;
      tick_sensor_ok <= sensor_valid;
      tick_minute    <= minute_of_day;
      tick_clock_ok  <= clock_valid;
    end
  end

  // Evaluate one tick against the current state.
  always_comb begin
    // Advance the phase timer in every mode, saturating at all ones.
    elapsed_sum   = {1'b0, phase_elapsed} + {17'd0, tick_elapsed};
    elapsed_sat   = elapsed_sum[32] ? '1 : elapsed_sum[31:0];
    phase_len     = phase_is_on ? cyclic_on_ms : cyclic_off_ms;

    // Minutes since the window opened, modulo one day.
    now_minute    = wrap_day(tick_minute);
    window_diff   = {1'b0, now_minute} - {1'b0, window_start};
    window_offset = window_diff[11] ? window_diff[10:0] + MINUTES_PER_DAY
                                    : window_diff[10:0];

    relay_state_next   = relay_state;
    phase_is_on_next   = phase_is_on;
    phase_elapsed_next = elapsed_sat;
    event_next         = 1'b0;

    unique case (relay_mode)
      MODE_FORCED: begin
        relay_state_next = manual_target;
      end
      MODE_HYSTERESIS: begin
        // Hysteresis; hold on an invalid reading.
        if (tick_sensor_ok) begin
          if (!relay_state && (tick_value >= on_threshold)) begin
            relay_state_next = 1'b1;
            event_next       = 1'b1;
          end else if (relay_state && (tick_value <= off_threshold)) begin
            relay_state_next = 1'b0;
            event_next       = 1'b1;
          end
        end
      end
      MODE_CYCLIC: begin
        // Flip the phase once its length is reached and restart the timer.
        if (elapsed_sat >= phase_len) begin
          phase_is_on_next   = !phase_is_on;
          phase_elapsed_next = '0;
          event_next         = 1'b1;
        end
        relay_state_next = phase_is_on_next;
      end
      MODE_SCHEDULED: begin
        // Hold while the wall clock is not synchronized.
        if (tick_clock_ok) begin
          relay_state_next = ({5'd0, window_offset} < window_length);
        end
      end
      default: begin
        relay_state_next = relay_state;
      end
    endcase

    changed_next = relay_state_next != relay_state;
    if (changed_next) begin
      event_next = 1'b1;
    end
  end

  // Configuration writes and state updates. The user must write only while idle, so
  // a restart of the cyclic phase never meets a tick in the same cycle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      relay_mode    <= MODE_FORCED;
      manual_target <= 1'b0;
      on_threshold  <= ON_THRESHOLD_RESET;
      off_threshold <= OFF_THRESHOLD_RESET;
      cyclic_on_ms  <= CYCLIC_ON_MS_RESET;
      cyclic_off_ms <= CYCLIC_OFF_MS_RESET;
      window_start  <= WINDOW_START_RESET;
      window_length <= WINDOW_LENGTH_RESET;
      relay_state   <= 1'b0;
      phase_is_on   <= 1'b0;
      phase_elapsed <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RELAY_MODE: begin
          relay_mode <= mode_t'(cfg_data[1:0]);
          if (mode_t'(cfg_data[1:0]) == MODE_CYCLIC) begin
            phase_is_on   <= 1'b1;
            phase_elapsed <= '0;
          end
        end
        CFG_MANUAL_TARGET: manual_target <= cfg_data[0];
        CFG_ON_THRESHOLD:  on_threshold  <= reading_t'(cfg_data[23:0]);
        CFG_OFF_THRESHOLD: off_threshold <= reading_t'(cfg_data[23:0]);
        CFG_CYCLIC_ON:     cyclic_on_ms  <= {16'd0, cfg_data[15:0]} * MS_PER_MINUTE;
        CFG_CYCLIC_OFF:    cyclic_off_ms <= {16'd0, cfg_data[15:0]} * MS_PER_MINUTE;
        CFG_WINDOW_START:  window_start  <= wrap_day(cfg_data[10:0]);
        CFG_WINDOW_LENGTH: window_length <= cfg_data[15:0];
        default: begin
          relay_mode <= relay_mode;
        end
      endcase
    end else if (tick_move) begin
      relay_state   <= relay_state_next;
      phase_is_on   <= phase_is_on_next;
      phase_elapsed <= phase_elapsed_next;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_move) begin
      relay_on      <= relay_state_next;
      state_changed <= changed_next;
      report_event  <= event_next;
    end
  end

endmodule

### rtl/core/rmc_checker.sv
// ----------------------------------------------------------------------------
// Relay mode controller checker
// Port-level assertions on the relay controller result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "relay_mode_controller_defines.svh"

module rmc_checker (
  input  logic clk,
  input  logic rst,
  input  logic out_valid,
  input  logic out_ready,
  input  logic relay_on,
  input  logic state_changed,
  input  logic report_event
);

  // Relay state as last delivered; off after reset.
  logic last_relay;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_relay <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_relay <= relay_on;
    end
  end

  `RMC_ASSERT_NOW(a_changed_matches, clk, rst, out_valid,
    state_changed == (relay_on != last_relay), "state_changed disagrees with relay history")

  `RMC_ASSERT_NOW(a_change_reports, clk, rst, out_valid && state_changed,
    report_event, "state change without report_event")

  `RMC_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready,
    out_valid && $stable(relay_on) && $stable(state_changed) && $stable(report_event),
    "result changed while stalled")

  `RMC_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst), !out_valid,
    "result valid right after reset")

endmodule

bind relay_mode_controller rmc_checker u_rmc_checker (.*);

### dv/relay_mode_controller_test.sv
// ----------------------------------------------------------------------------
// Relay mode controller testbench
// Runs evaluation ticks through the relay controller in all four modes and
// checks every result, field by field, against an in-bench prediction of
// relay state, hysteresis, cyclic phase timer and daily window. Both
// channels idle and stall at random; registers change only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module relay_mode_controller_test;
  import rmc_pkg::*;

  localparam reading_t ReadingMin = 24'h80_0000;
  localparam reading_t ReadingMax = 24'h7F_FFFF;
  localparam int unsigned TickCount = 1110;

  // One evaluation tick as driven onto the input channel.
  typedef struct {
    ms_delta_t elapsed;
    reading_t  reading;
    logic      reading_ok;
    minute_t   minute;
    logic      clock_ok;
  } tick_t;

  // One result transaction.
  typedef struct {
    logic relay_on;
    logic changed;
    logic report;
  } outcome_t;

  // --------------------------------------------------------------------------
  // Relay outcome board: shadow registers and relay/phase state, the queue of
  // predicted outcomes, and the mismatch count.
  // --------------------------------------------------------------------------
  class relay_outcome_board;
    mode_t        mode;
    logic         manual_on;
    reading_t     on_level;
    reading_t     off_level;
    minutes_len_t on_minutes;
    minutes_len_t off_minutes;
    minute_t      window_start;
    minutes_len_t window_minutes;
    logic         relay;
    logic         in_on_phase;
    ms_count_t    phase_ms;
    outcome_t     pending_outcomes[$];
    int unsigned  errors;

    function new();
      mode           = MODE_FORCED;
      manual_on      = 1'b0;
      on_level       = ON_THRESHOLD_RESET;
      off_level      = OFF_THRESHOLD_RESET;
      on_minutes     = minutes_len_t'(CYCLIC_ON_MS_RESET / MS_PER_MINUTE);
      off_minutes    = minutes_len_t'(CYCLIC_OFF_MS_RESET / MS_PER_MINUTE);
      window_start   = WINDOW_START_RESET;
      window_minutes = WINDOW_LENGTH_RESET;
      relay          = 1'b0;
      in_on_phase    = 1'b0;
      phase_ms       = '0;
      errors         = 0;
    endfunction

    function void write_register(cfg_index_t idx, cfg_data_t data);
      case (idx)
        CFG_RELAY_MODE: begin
          mode = mode_t'(data[1:0]);
          if (mode == MODE_CYCLIC) begin
            in_on_phase = 1'b1;
            phase_ms    = '0;
          end
        end
        CFG_MANUAL_TARGET: manual_on = data[0];
        CFG_ON_THRESHOLD:  on_level = reading_t'(data);
        CFG_OFF_THRESHOLD: off_level = reading_t'(data);
        CFG_CYCLIC_ON:     on_minutes = data[15:0];
        CFG_CYCLIC_OFF:    off_minutes = data[15:0];
        CFG_WINDOW_START:  window_start = data[10:0];
        CFG_WINDOW_LENGTH: window_minutes = data[15:0];
        default: ;
      endcase
    endfunction

    // Evaluate one accepted tick and queue the outcome it must produce.
    function void note_tick(tick_t t);
      ms_count_t   phase_len;
      int unsigned day;
      int unsigned now_m;
      int unsigned start_m;
      int unsigned offset;
      logic        want;
      logic        flag;
      outcome_t    o;
      day  = MINUTES_PER_DAY;
      want = relay;
      flag = 1'b0;
      // The phase timer runs in every mode and saturates.
      if (phase_ms > 32'hFFFF_FFFF - ms_count_t'(t.elapsed)) phase_ms = '1;
      else phase_ms = phase_ms + ms_count_t'(t.elapsed);
      case (mode)
        MODE_FORCED: want = manual_on;
        MODE_HYSTERESIS: begin
          if (t.reading_ok) begin
            if (!relay && t.reading >= on_level) begin
              want = 1'b1;
              flag = 1'b1;
            end else if (relay && t.reading <= off_level) begin
              want = 1'b0;
              flag = 1'b1;
            end
          end
        end
        MODE_CYCLIC: begin
          phase_len = ms_count_t'(in_on_phase ? on_minutes : off_minutes) * MS_PER_MINUTE;
          if (phase_ms >= phase_len) begin
            in_on_phase = !in_on_phase;
            phase_ms    = '0;
            flag        = 1'b1;
          end
          want = in_on_phase;
        end
        default: begin
          if (t.clock_ok) begin
            now_m   = t.minute % day;
            start_m = window_start % day;
            offset  = (now_m + day - start_m) % day;
            want    = offset < window_minutes;
          end
        end
      endcase
      o.relay_on = want;
      o.changed  = want != relay;
      o.report   = flag | o.changed;
      relay      = want;
      pending_outcomes.push_back(o);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_outcome(outcome_t got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, relay_on=%0b", got.relay_on));
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.relay_on !== want.relay_on)
        report_mismatch($sformatf("relay_on %0b, wanted %0b", got.relay_on, want.relay_on));
      if (got.changed !== want.changed)
        report_mismatch($sformatf("state_changed %0b, wanted %0b", got.changed, want.changed));
      if (got.report !== want.report)
        report_mismatch($sformatf("report_event %0b, wanted %0b", got.report, want.report));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  ms_delta_t                elapsed_ms = '0;
  reading_t                 sensor_value = '0;
  logic                     sensor_valid = 1'b0;
  minute_t                  minute_of_day = '0;
  logic                     clock_valid = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     relay_on;
  logic                     state_changed;
  logic                     report_event;
  logic                     cfg_write = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  cfg_data_t                cfg_data = '0;

  relay_outcome_board board;
  // When set, that side runs back to back for a while.
  bit                 sender_calm = 1'b0;
  bit                 receiver_calm = 1'b0;
  int unsigned        ticks_sent = 0;

  relay_mode_controller DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .elapsed_ms    (elapsed_ms),
    .sensor_value  (sensor_value),
    .sensor_valid  (sensor_valid),
    .minute_of_day (minute_of_day),
    .clock_valid   (clock_valid),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .relay_on      (relay_on),
    .state_changed (state_changed),
    .report_event  (report_event),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Present one tick after a random gap, hold it until the transaction
  // completes, then hand it to the board. Valid stays high on return so the
  // next tick can follow back to back.
  task automatic send_tick(tick_t t);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    elapsed_ms    <= t.elapsed;
    sensor_value  <= t.reading;
    sensor_valid  <= t.reading_ok;
    minute_of_day <= t.minute;
    clock_valid   <= t.clock_ok;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.note_tick(t);
    ticks_sent++;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
  endtask

  // Drop valid and wait until every predicted outcome has come back, then
  // let the two-stage pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Hold the write strobe high across consecutive writes; close_writes drops it.
  task automatic write_reg(cfg_index_t idx, cfg_data_t data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_register(idx, data);
  endtask

  task automatic close_writes();
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic tick_t make_tick(ms_delta_t e, reading_t r, logic rok, minute_t m,
                                      logic cok);
    tick_t t;
    t.elapsed    = e;
    t.reading    = r;
    t.reading_ok = rok;
    t.minute     = m;
    t.clock_ok   = cok;
    return t;
  endfunction

  // Narrow registers sometimes get junk above their width; it must be dropped.
  function automatic cfg_data_t with_noise(int unsigned value, int unsigned width);
    cfg_data_t noisy;
    noisy = cfg_data_t'(value);
    if ($urandom_range(0, 3) == 0) noisy = noisy | (cfg_data_t'($urandom) << width);
    return noisy;
  endfunction

  // Setpoints: mostly a narrow band so readings cross them, sometimes extremes.
  function automatic reading_t pick_level();
    case ($urandom_range(0, 5))
      0:       return ReadingMax;
      1:       return ReadingMin;
      default: return reading_t'($urandom_range(0, 4000)) - 24'sd2000;
    endcase
  endfunction

  // Phase lengths: short ones flip often; the longest almost never flips.
  function automatic int unsigned pick_minutes();
    case ($urandom_range(0, 7))
      0:       return 65535;
      1:       return $urandom_range(0, 65535);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic int unsigned pick_window();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(0, 65535);
      default: return $urandom_range(0, 1500);
    endcase
  endfunction

  function automatic int unsigned pick_start();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1439;
      2:       return 2047;
      default: return $urandom_range(0, 2047);
    endcase
  endfunction

  // Random tick aimed at the current setpoints and window edges.
  function automatic tick_t random_tick();
    tick_t       t;
    int          level;
    int unsigned start_m;
    int unsigned lane;
    case ($urandom_range(0, 7))
      0:       t.elapsed = '0;
      1:       t.elapsed = '1;
      default: t.elapsed = ms_delta_t'($urandom);
    endcase
    if ($urandom_range(0, 5) == 0) begin
      t.reading = reading_t'($urandom);
    end else begin
      level = $urandom_range(0, 1) ? int'(board.on_level) : int'(board.off_level);
      level = level + int'($urandom_range(0, 600)) - 300;
      if (level > 8388607) level = 8388607;
      if (level < -8388608) level = -8388608;
      t.reading = reading_t'(level);
    end
    t.reading_ok = $urandom_range(0, 7) != 0;
    start_m = board.window_start % MINUTES_PER_DAY;
    case ($urandom_range(0, 3))
      0: lane = (start_m + board.window_minutes) % MINUTES_PER_DAY;
      1: lane = (start_m + board.window_minutes + 1439) % MINUTES_PER_DAY;
      default: lane = $urandom_range(0, 2047);
    endcase
    // Fold some minutes into the second day to exercise the modulo.
    if (lane < 608 && $urandom_range(0, 2) == 0) lane = lane + MINUTES_PER_DAY;
    t.minute   = minute_t'(lane);
    t.clock_ok = $urandom_range(0, 7) != 0;
    return t;
  endfunction

  // Idle the block, then rewrite a random subset of registers. Write the mode
  // last; cyclic mode restarts its on phase on every such write.
  task automatic reconfigure(bit write_all);
    settle();
    if (write_all || $urandom_range(0, 1))
      write_reg(CFG_MANUAL_TARGET, with_noise($urandom_range(0, 1), 1));
    if (write_all || $urandom_range(0, 1)) write_reg(CFG_ON_THRESHOLD, pick_level());
    if (write_all || $urandom_range(0, 1)) write_reg(CFG_OFF_THRESHOLD, pick_level());
    if (write_all || $urandom_range(0, 1))
      write_reg(CFG_CYCLIC_ON, with_noise(pick_minutes(), 16));
    if (write_all || $urandom_range(0, 1))
      write_reg(CFG_CYCLIC_OFF, with_noise(pick_minutes(), 16));
    if (write_all || $urandom_range(0, 1))
      write_reg(CFG_WINDOW_START, with_noise(pick_start(), 11));
    if (write_all || $urandom_range(0, 1))
      write_reg(CFG_WINDOW_LENGTH, with_noise(pick_window(), 16));
    if (write_all || $urandom_range(0, 3) != 0)
      write_reg(CFG_RELAY_MODE, with_noise($urandom_range(0, 3), 2));
    close_writes();
  endtask

  // Field extremes, every mode, and the hold and wrap cases.
  task automatic run_directed();
    // Manual with reset values: relay stays off whatever the inputs; then target on.
    send_tick(make_tick('0, ReadingMin, 1'b0, 11'd0, 1'b0));
    send_tick(make_tick('1, ReadingMax, 1'b1, 11'd2047, 1'b1));
    settle();
    write_reg(CFG_MANUAL_TARGET, cfg_data_t'(1));
    close_writes();
    send_tick(make_tick(16'd1, '0, 1'b1, 11'd1439, 1'b1));
    send_tick(make_tick(16'd2, '0, 1'b0, 11'd1, 1'b0));

    // Auto with thresholds at the reading limits; the relay enters on.
    settle();
    write_reg(CFG_ON_THRESHOLD, ReadingMax);
    write_reg(CFG_OFF_THRESHOLD, ReadingMin);
    write_reg(CFG_RELAY_MODE, cfg_data_t'(MODE_HYSTERESIS));
    close_writes();
    send_tick(make_tick(16'd5, ReadingMin, 1'b0, 11'd3, 1'b1));
    send_tick(make_tick(16'd5, ReadingMin + 24'sd1, 1'b1, 11'd3, 1'b1));
    send_tick(make_tick(16'd5, ReadingMin, 1'b1, 11'd3, 1'b1));
    send_tick(make_tick(16'd5, ReadingMax, 1'b0, 11'd3, 1'b1));
    send_tick(make_tick(16'd5, ReadingMax - 24'sd1, 1'b1, 11'd3, 1'b1));
    send_tick(make_tick(16'd5, ReadingMax, 1'b1, 11'd3, 1'b1));

    // Cyclic with zero-length phases: flip on every tick.
    settle();
    write_reg(CFG_CYCLIC_ON, '0);
    write_reg(CFG_CYCLIC_OFF, '0);
    write_reg(CFG_RELAY_MODE, cfg_data_t'(MODE_CYCLIC));
    close_writes();
    repeat (3) send_tick(make_tick('0, '0, 1'b0, 11'd0, 1'b0));

    // One-minute on phase: flip exactly at 60000 ms, then a very long off phase.
    settle();
    write_reg(CFG_CYCLIC_ON, cfg_data_t'(1));
    write_reg(CFG_CYCLIC_OFF, cfg_data_t'(65535));
    write_reg(CFG_RELAY_MODE, cfg_data_t'(MODE_CYCLIC));
    close_writes();
    send_tick(make_tick(16'd59999, '0, 1'b1, 11'd0, 1'b1));
    send_tick(make_tick(16'd1, '0, 1'b1, 11'd0, 1'b1));
    send_tick(make_tick('1, '0, 1'b1, 11'd0, 1'b1));

    // Scheduled window wrapping past midnight, second-day minutes, bad clock.
    settle();
    write_reg(CFG_WINDOW_START, cfg_data_t'(1439));
    write_reg(CFG_WINDOW_LENGTH, cfg_data_t'(2));
    write_reg(CFG_RELAY_MODE, cfg_data_t'(MODE_SCHEDULED));
    close_writes();
    send_tick(make_tick(16'd7, '0, 1'b0, 11'd1439, 1'b1));
    send_tick(make_tick(16'd7, '0, 1'b0, 11'd0, 1'b1));
    send_tick(make_tick(16'd7, '0, 1'b0, 11'd1, 1'b1));
    send_tick(make_tick(16'd7, '0, 1'b0, 11'd1440, 1'b1));
    send_tick(make_tick(16'd7, '0, 1'b0, 11'd1, 1'b0));

    // Start beyond one day folds back; an empty window is always off.
    settle();
    write_reg(CFG_WINDOW_START, cfg_data_t'(2047));
    write_reg(CFG_WINDOW_LENGTH, '0);
    close_writes();
    send_tick(make_tick(16'd7, '0, 1'b0, 11'd607, 1'b1));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed ticks, then random phases separated by idle
  // register rewrites (each rewrite also pauses the sender until drained).
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_len;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    reconfigure(1'b1);
    while (ticks_sent < TickCount) begin
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) send_tick(random_tick());
      reconfigure(1'b0);
    end
    settle();
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: stall a random number of cycles per result, then take it.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    outcome_t    got;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = receiver_calm ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.relay_on = relay_on;
      got.changed  = state_changed;
      got.report   = report_event;
      board.check_outcome(got);
      if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
    end
  end

  // Give up long after the slowest correct run would have finished.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/rmc_pkg.sv
rtl/core/relay_mode_controller.sv
rtl/core/rmc_checker.sv
dv/relay_mode_controller_test.sv
